// ----- rtl/core/ppc_pkg.sv -----
// Shared types and constants for the port probe reply classifier.
package ppc_pkg;

  localparam logic [2:0] ST_UNKNOWN  = 3'd0;
  localparam logic [2:0] ST_OPEN     = 3'd1;
  localparam logic [2:0] ST_CLOSED   = 3'd2;
  localparam logic [2:0] ST_FILTERED = 3'd3;
  localparam logic [2:0] ST_UNFILT   = 3'd4;
  localparam logic [2:0] ST_OPEN_FLT = 3'd5;

  localparam logic [2:0] MODE_SYN  = 3'd0;
  localparam logic [2:0] MODE_ACK  = 3'd1;
  localparam logic [2:0] MODE_FIN  = 3'd2;
  localparam logic [2:0] MODE_XMAS = 3'd4;
  localparam logic [2:0] MODE_UDP  = 3'd5;

  localparam logic [2:0] REG_LINK_KIND   = 3'd0;
  localparam logic [2:0] REG_SCAN_MODE   = 3'd1;
  localparam logic [2:0] REG_TARGET_PORT = 3'd2;
  localparam logic [2:0] REG_LOCAL_PORT  = 3'd3;
  localparam logic [2:0] REG_TARGET_ADDR = 3'd4;
  localparam logic [2:0] REG_LOCAL_ADDR  = 3'd5;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PORT_UNREACH = 8'd3;
  localparam logic [8:0] ETH_HDR_LEN = 9'd14;
  localparam logic [8:0] SLL_HDR_LEN = 9'd16;
  localparam logic [8:0] ICMP_INNER_OFF = 9'd8;

  localparam int QDEPTH = 2;

  // per-job summary (frame end or wait-over) handed from front to back
  typedef struct packed {
    logic       is_final;
    logic [2:0] state;
  } job_t;

  typedef struct packed {
    logic [1:0]  link_kind;
    logic [2:0]  scan_mode;
    logic [15:0] target_port;
    logic [15:0] local_port;
    logic [31:0] target_addr;
    logic [31:0] local_addr;
  } cfg_t;

endpackage

// ----- rtl/core/port_probe_reply_classifier.sv -----
// A frame-end or wait-over item's result passes through the job queue and then the output register.
// Throughput: one byte item per cycle while the job queue is not full; the classifier works on the byte in flight.
// A two-entry job queue decouples the parser from the output register.
// Reset (synchronous, active low) clears configuration, queue count, frame state and verdict latch.
// Top level of the port probe reply classifier.
module port_probe_reply_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] frame_decisive, [3:1] port_state
  output logic        out_tuser,  // verdict_kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import ppc_pkg::*;

  cfg_t cfg_r;
  logic in_go, fj_valid, q_full, q_valid, q_take;
  job_t fj, qj;
  logic [7:0] bd;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else if (cfg_we) begin
      case (cfg_index)
        REG_LINK_KIND:   cfg_r.link_kind   <= cfg_wdata[1:0];
        REG_SCAN_MODE:   cfg_r.scan_mode   <= cfg_wdata[2:0];
        REG_TARGET_PORT: cfg_r.target_port <= cfg_wdata[15:0];
        REG_LOCAL_PORT:  cfg_r.local_port  <= cfg_wdata[15:0];
        REG_TARGET_ADDR: cfg_r.target_addr <= cfg_wdata;
        REG_LOCAL_ADDR:  cfg_r.local_addr  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign in_go = in_tvalid && in_tready;

  ppc_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .in_go(in_go), .op(in_tuser),
    .data(in_tdata), .last(in_tlast), .job_valid(fj_valid), .job(fj)
  );

  ppc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(fj_valid), .wr_job(fj), .full(q_full),
    .rd_valid(q_valid), .rd_en(q_take), .rd_job(qj)
  );

  ppc_back u_back (
    .clk(clk), .rst_n(rst_n), .scan_mode(cfg_r.scan_mode), .job_valid(q_valid),
    .job(qj), .job_take(q_take), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(bd)
  );

  assign out_tuser = bd[0];
  assign out_tdata = {4'd0, bd[4:1]};

endmodule

// ----- rtl/core/ppc_front.sv -----
// Front part: byte capture and per-frame classification.
module ppc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  ppc_pkg::cfg_t cfg,
  input  logic          in_go,
  input  logic          op,
  input  logic [7:0]    data,
  input  logic          last,
  output logic          job_valid,
  output ppc_pkg::job_t job
);
  import ppc_pkg::*;

  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  vihl_r, vihl_nxt, proto_r, proto_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic [31:0] ports_r, ports_nxt;
  logic [5:0]  flags_r, flags_nxt;
  logic [15:0] icmp_r, icmp_nxt;
  logic [15:0] inner_r, inner_nxt;
  logic [31:0] iports_r, iports_nxt;

  logic [8:0] p, L, t, ii, j, n;
  logic [7:0] ihl2b;
  logic [2:0] st;
  logic [3:0] ihl, ihl2;

  always_comb begin
    p = {1'b0, pos_r};
    case (cfg.link_kind)
      2'd1:    L = ETH_HDR_LEN;
      2'd2:    L = SLL_HDR_LEN;
      default: L = 9'd0;
    endcase
    vihl_nxt = vihl_r; proto_nxt = proto_r; addr_nxt = addr_r; ports_nxt = ports_r;
    flags_nxt = flags_r; icmp_nxt = icmp_r; inner_nxt = inner_r; iports_nxt = iports_r;
    if (p == L) vihl_nxt = data;
    if (p == L + 9'd9) proto_nxt = data;
    if (p >= L + 9'd12 && p < L + 9'd20)
      addr_nxt[8'(7 - 3'(p - L - 9'd12)) * 8 +: 8] = data;
    ihl = vihl_nxt[3:0];
    t = L + {3'd0, ihl, 2'b00};
    ii = t + ICMP_INNER_OFF;
    if (ihl >= 4'd5) begin
      if (p >= t && p < t + 9'd4) ports_nxt[(3 - 2'(p - t)) * 8 +: 8] = data;
      if (p == t + 9'd13) flags_nxt = data[5:0];
      if (p == t) icmp_nxt[15:8] = data;
      if (p == t + 9'd1) icmp_nxt[7:0] = data;
      if (p == ii) inner_nxt[15:8] = data;
      if (p == ii + 9'd9) inner_nxt[7:0] = data;
    end
    ihl2 = inner_nxt[11:8];
    ihl2b = {2'd0, ihl2, 2'b00};
    j = ii + {1'b0, ihl2b};
    if (ihl >= 4'd5 && ihl2 >= 4'd5 && p >= j && p < j + 9'd4)
      iports_nxt[(3 - 2'(p - j)) * 8 +: 8] = data;
    pos_nxt = (pos_r != 8'hFF) ? pos_r + 8'd1 : pos_r;
    n = {1'b0, pos_nxt};

    st = ST_UNKNOWN;
    if (vihl_nxt[7:4] == 4'd4 && ihl >= 4'd5 && n >= L + 9'd20 &&
        addr_nxt[63:32] == cfg.target_addr && addr_nxt[31:0] == cfg.local_addr) begin
      if (cfg.scan_mode <= MODE_XMAS) begin
        if (proto_nxt == PROTO_TCP && n >= t + 9'd14 && ports_nxt[31:16] == cfg.target_port
            && ports_nxt[15:0] == cfg.local_port) begin
          if (cfg.scan_mode == MODE_SYN) begin
            if (flags_nxt[4] && flags_nxt[1]) st = ST_OPEN;
            else if (flags_nxt[2]) st = ST_CLOSED;
          end else if (cfg.scan_mode == MODE_ACK) begin
            if (flags_nxt[2]) st = ST_UNFILT;
          end else if (flags_nxt[2]) st = ST_CLOSED;
        end
      end else if (cfg.scan_mode == MODE_UDP) begin
        if (proto_nxt == PROTO_UDP) begin
          if (n >= t + 9'd4 && ports_nxt[31:16] == cfg.target_port &&
              ports_nxt[15:0] == cfg.local_port) st = ST_OPEN;
        end else if (proto_nxt == PROTO_ICMP) begin
          if (n >= t + 9'd2 && icmp_nxt == {PORT_UNREACH, PORT_UNREACH} &&
              inner_nxt[15:12] == 4'd4 && ihl2 >= 4'd5 && inner_nxt[7:0] == PROTO_UDP &&
              n >= j + 9'd4 && iports_nxt[31:16] == cfg.local_port &&
              iports_nxt[15:0] == cfg.target_port) st = ST_CLOSED;
        end
      end
    end
  end

  assign job_valid = in_go && (op || last);
  assign job.is_final = op;
  assign job.state = op ? ST_UNKNOWN : st;

  always_ff @(posedge clk) begin
    if (!rst_n || (in_go && (op || last))) begin
      pos_r <= '0; vihl_r <= '0; proto_r <= '0; addr_r <= '0; ports_r <= '0;
      flags_r <= '0; icmp_r <= '0; inner_r <= '0; iports_r <= '0;
    end else if (in_go) begin
      pos_r <= pos_nxt; vihl_r <= vihl_nxt; proto_r <= proto_nxt; addr_r <= addr_nxt;
      ports_r <= ports_nxt; flags_r <= flags_nxt; icmp_r <= icmp_nxt;
      inner_r <= inner_nxt; iports_r <= iports_nxt;
    end
  end

endmodule

// ----- rtl/core/ppc_queue.sv -----
// Short job queue between front and back.
module ppc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  ppc_pkg::job_t wr_job,
  output logic          full,
  output logic          rd_valid,
  input  logic          rd_en,
  output ppc_pkg::job_t rd_job
);
  import ppc_pkg::*;

  job_t       mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'(QDEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// ----- rtl/core/ppc_back.sv -----
// Back part: verdict latch and output register.
module ppc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    scan_mode,
  input  logic          job_valid,
  input  ppc_pkg::job_t job,
  output logic          job_take,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata
);
  import ppc_pkg::*;

  logic       dec_r;
  logic [2:0] lat_r;
  logic       ov_r;
  logic [4:0] od_r, od_nxt;

  assign job_take = job_valid && (!ov_r || out_tready);
  assign out_tvalid = ov_r;
  assign out_tdata = {3'd0, od_r};

  always_comb begin
    if (job.is_final) begin
      if (dec_r) od_nxt = {lat_r, 1'b0, 1'b1};
      else if (scan_mode <= MODE_ACK) od_nxt = {ST_FILTERED, 2'b01};
      else if (scan_mode <= MODE_UDP) od_nxt = {ST_OPEN_FLT, 2'b01};
      else od_nxt = {ST_UNKNOWN, 2'b01};
    end else begin
      od_nxt = {job.state, (job.state != ST_UNKNOWN), 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) od_r <= od_nxt;
    if (!rst_n) begin
      ov_r <= 1'b0; dec_r <= 1'b0; lat_r <= '0;
    end else begin
      if (job_take) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      if (job_take) begin
        if (job.is_final) begin
          dec_r <= 1'b0; lat_r <= '0;
        end else if (job.state != ST_UNKNOWN && !dec_r) begin
          dec_r <= 1'b1; lat_r <= job.state;
        end
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the port probe reply classifier: framed byte stimulus, local predictor, checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ppc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;  // [7:0] data_byte
  logic        in_tlast = 1'b0;  // last_byte
  logic        in_tuser = 1'b0;  // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;  // [0] frame_decisive, [3:1] port_state
  logic        out_tuser;  // verdict_kind
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  port_probe_reply_classifier u_top (.*);

  always #2 clk = ~clk;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic       kind;
    logic       decisive;
    logic [2:0] state;
  } verdict_t;

  byte_item_t pending_q[$];
  verdict_t   verdict_q[$];

  // predictor copy of configuration and state
  logic [1:0]  m_link;
  logic [2:0]  m_mode;
  logic [15:0] m_tport, m_lport;
  logic [31:0] m_taddr, m_laddr;
  int unsigned pos;
  logic [7:0]  vihl, proto, ivihl, iproto, flags;
  logic [63:0] addrs;
  logic [31:0] tports, iports;
  logic [15:0] icmp_tc;
  logic        decided;
  logic [2:0]  latched;

  int errors = 0;
  int n_frames = 0, n_decisive = 0, n_final = 0;
  longint cycles = 0;
  bit     hold_go = 0;
  bit     hold_seen = 0;
  int     hold_cnt = 0;
  bit     no_idle = 0;

  function automatic logic [31:0] put_b(logic [31:0] w, int unsigned k, logic [7:0] b);
    w[(3 - k) * 8 +: 8] = b;
    return w;
  endfunction

  task automatic clear_parse();
    pos = 0; vihl = 0; proto = 0; ivihl = 0; iproto = 0; flags = 0;
    addrs = 0; tports = 0; iports = 0; icmp_tc = 0;
  endtask

  function automatic int unsigned hdr_len();
    if (m_link == 2'd1) return 14;
    if (m_link == 2'd2) return 16;
    return 0;
  endfunction

  task automatic capture_byte(int unsigned p, logic [7:0] b);
    int unsigned lh, t, ii, j;
    lh = hdr_len();
    if (p == lh) vihl = b;
    if (p == lh + 9) proto = b;
    if (p >= lh + 12 && p < lh + 20) addrs[(7 - (p - lh - 12)) * 8 +: 8] = b;
    if (vihl[3:0] < 5) return;
    t = lh + vihl[3:0] * 4;
    if (p >= t && p < t + 4) tports = put_b(tports, p - t, b);
    if (p == t + 13) flags = b & 8'h3f;
    if (p == t) icmp_tc[15:8] = b;
    if (p == t + 1) icmp_tc[7:0] = b;
    ii = t + 8;
    if (p == ii) ivihl = b;
    if (p == ii + 9) iproto = b;
    if (ivihl[3:0] < 5) return;
    j = ii + ivihl[3:0] * 4;
    if (p >= j && p < j + 4) iports = put_b(iports, p - j, b);
  endtask

  function automatic logic [2:0] classify_frame(int unsigned n);
    int unsigned lh, t, j;
    logic [15:0] sp, dp;
    lh = hdr_len();
    if (vihl[7:4] != 4 || vihl[3:0] < 5 || n < lh + 20) return ST_UNKNOWN;
    if (addrs[63:32] != m_taddr || addrs[31:0] != m_laddr) return ST_UNKNOWN;
    t = lh + vihl[3:0] * 4;
    sp = tports[31:16];
    dp = tports[15:0];
    if (m_mode <= MODE_XMAS) begin
      if (proto != PROTO_TCP || n < t + 14 || sp != m_tport || dp != m_lport) return ST_UNKNOWN;
      if (m_mode == MODE_SYN) begin
        if (flags[4] && flags[1]) return ST_OPEN;
        if (flags[2]) return ST_CLOSED;
        return ST_UNKNOWN;
      end
      if (m_mode == MODE_ACK) return flags[2] ? ST_UNFILT : ST_UNKNOWN;
      return flags[2] ? ST_CLOSED : ST_UNKNOWN;
    end
    if (m_mode == MODE_UDP) begin
      if (proto == PROTO_UDP) begin
        if (n >= t + 4 && sp == m_tport && dp == m_lport) return ST_OPEN;
        return ST_UNKNOWN;
      end
      if (proto == PROTO_ICMP) begin
        if (n < t + 2 || icmp_tc != {PORT_UNREACH, PORT_UNREACH}) return ST_UNKNOWN;
        if (ivihl[7:4] != 4 || ivihl[3:0] < 5 || iproto != PROTO_UDP) return ST_UNKNOWN;
        j = t + 8 + ivihl[3:0] * 4;
        if (n < j + 4) return ST_UNKNOWN;
        if (iports[31:16] == m_lport && iports[15:0] == m_tport) return ST_CLOSED;
      end
    end
    return ST_UNKNOWN;
  endfunction

  task automatic predict_item(byte_item_t it);
    verdict_t v;
    logic [2:0] st;
    if (it.op) begin
      if (decided) st = latched;
      else if (m_mode <= MODE_ACK) st = ST_FILTERED;
      else if (m_mode <= MODE_UDP) st = ST_OPEN_FLT;
      else st = ST_UNKNOWN;
      v = '{kind: 1'b1, decisive: 1'b0, state: st};
      verdict_q.push_back(v);
      clear_parse();
      decided = 0; latched = ST_UNKNOWN;
      return;
    end
    capture_byte(pos, it.data);
    if (pos < 255) pos++;
    if (!it.last) return;
    st = classify_frame(pos);
    if (st != ST_UNKNOWN && !decided) begin
      decided = 1; latched = st;
    end
    v = '{kind: 1'b0, decisive: st != ST_UNKNOWN, state: st};
    verdict_q.push_back(v);
    clear_parse();
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_item(pending_q.pop_front());
      if ((!in_tvalid || in_tready) && pending_q.size() > 0 &&
          (no_idle || $urandom_range(99) >= 7)) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_q[0].op;
        in_tdata  <= pending_q[0].data;
        in_tlast  <= pending_q[0].last;
      end else if (!in_tvalid || in_tready) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cnt  <= 300;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t got, exp;
    if (rst_n) begin
      out_tready <= (hold_cnt == 0) && !(hold_go && !hold_seen) &&
                    (no_idle || $urandom_range(99) >= 7);
      if (out_tvalid && out_tready) begin
        got = '{kind: out_tuser, decisive: out_tdata[0], state: out_tdata[3:1]};
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected verdict %p", got);
        end else begin
          exp = verdict_q.pop_front();
          if (got !== exp || out_tdata[7:4] !== 4'd0) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", exp, got);
          end
          if (got.kind) n_final++;
          else begin
            n_frames++;
            if (got.decisive) n_decisive++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    case (idx)
      REG_LINK_KIND:   m_link  = val[1:0];
      REG_SCAN_MODE:   m_mode  = val[2:0];
      REG_TARGET_PORT: m_tport = val[15:0];
      REG_LOCAL_PORT:  m_lport = val[15:0];
      REG_TARGET_ADDR: m_taddr = val;
      REG_LOCAL_ADDR:  m_laddr = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_tvalid || verdict_q.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic push_byte(logic [7:0] b, logic last);
    byte_item_t it;
    it = '{op: 1'b0, data: b, last: last};
    pending_q.push_back(it);
  endtask

  task automatic push_wait_over();
    byte_item_t it;
    it = '{op: 1'b1, data: 8'($urandom), last: 1'($urandom)};
    pending_q.push_back(it);
  endtask

  // frame builder: well-formed reply with knobs for breaking it
  task automatic push_frame(int unsigned proto_sel, logic [7:0] tcp_flags, int unsigned ihl,
                            bit bad_addr, bit bad_port, int cut);
    logic [7:0] f[$];
    int unsigned lh, n;
    lh = hdr_len();
    repeat (lh) f.push_back(8'($urandom));
    f.push_back({4'd4, 4'(ihl)});
    repeat (8) f.push_back(8'($urandom));
    f.push_back(proto_sel == 0 ? PROTO_TCP : proto_sel == 1 ? PROTO_UDP :
                proto_sel == 2 ? PROTO_ICMP : 8'($urandom));
    repeat (2) f.push_back(8'($urandom));
    for (int k = 3; k >= 0; k--) f.push_back(m_taddr[k*8 +: 8] ^ (bad_addr ? 8'h01 : 8'h00));
    for (int k = 3; k >= 0; k--) f.push_back(m_laddr[k*8 +: 8]);
    while (f.size() < lh + ihl * 4) f.push_back(8'($urandom));
    if (proto_sel == 2) begin
      f.push_back(PORT_UNREACH); f.push_back($urandom_range(1) ? PORT_UNREACH : 8'd1);
      repeat (6) f.push_back(8'($urandom));
      f.push_back({4'd4, 4'($urandom_range(5, 6))});
      repeat (8) f.push_back(8'($urandom));
      f.push_back($urandom_range(3) != 0 ? PROTO_UDP : PROTO_TCP);
      while (f.size() < lh + ihl * 4 + 8 + (f[lh + ihl * 4 + 8] & 15) * 4)
        f.push_back(8'($urandom));
      f.push_back(m_lport[15:8]); f.push_back(m_lport[7:0] ^ (bad_port ? 8'h02 : 8'h00));
      f.push_back(m_tport[15:8]); f.push_back(m_tport[7:0]);
    end else begin
      f.push_back(m_tport[15:8]); f.push_back(m_tport[7:0] ^ (bad_port ? 8'h02 : 8'h00));
      f.push_back(m_lport[15:8]); f.push_back(m_lport[7:0]);
      repeat (9) f.push_back(8'($urandom));
      f.push_back(tcp_flags);
      repeat ($urandom_range(0, 6)) f.push_back(8'($urandom));
    end
    n = f.size();
    if (cut > 0 && cut < n) n = n - cut;
    for (int k = 0; k < n; k++) push_byte(f[k], k == n - 1);
  endtask

  task automatic random_config(bit extreme);
    write_reg(REG_LINK_KIND, extreme ? 32'd3 : $urandom_range(2));
    write_reg(REG_SCAN_MODE, $urandom_range(99) < 8 ? $urandom_range(6, 7) : $urandom_range(5));
    write_reg(REG_TARGET_PORT, extreme ? 32'hffff : $urandom);
    write_reg(REG_LOCAL_PORT, extreme ? 32'h0 : $urandom);
    write_reg(REG_TARGET_ADDR, extreme ? 32'hffff_ffff : $urandom);
    write_reg(REG_LOCAL_ADDR, extreme ? 32'h0 : $urandom);
  endtask

  task automatic random_frame();
    int r;
    logic [7:0] fl;
    r = $urandom_range(99);
    fl = $urandom_range(1) ? 8'($urandom) : ($urandom_range(1) ? 8'h12 : 8'h14);
    if (r < 70)
      push_frame(m_mode == MODE_UDP ? $urandom_range(1, 2) : 0, fl, $urandom_range(5, 7),
                 0, $urandom_range(9) == 0, 0);
    else if (r < 85)
      push_frame($urandom_range(3), fl, $urandom_range(3, 15), $urandom_range(1),
                 $urandom_range(1), $urandom_range(0, 30));
    else
      repeat ($urandom_range(1, 40)) push_byte(8'($urandom), $urandom_range(20) == 0);
    if ($urandom_range(9) == 0) push_wait_over();
  endtask

  initial begin
    m_link = 0; m_mode = 0; m_tport = 0; m_lport = 0; m_taddr = 0; m_laddr = 0;
    clear_parse();
    decided = 0; latched = ST_UNKNOWN;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every scan mode and link kind, decided and defaulted final verdicts
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_SCAN_MODE, m);
      if (m == 0) begin
        push_wait_over();
        drain();
        write_reg(REG_TARGET_ADDR, 32'hc0a8_0001);
        write_reg(REG_LOCAL_ADDR, 32'h0a00_0002);
        write_reg(REG_TARGET_PORT, 32'd80);
        write_reg(REG_LOCAL_PORT, 32'd40000);
      end
      write_reg(REG_LINK_KIND, m % 4);
      push_frame(m == 5 ? 1 : 0, m == 0 ? 8'h12 : 8'h14, 5, 0, 0, 0);
      if (m == 5) push_frame(2, 8'h00, 5, 0, 0, 0);
      push_wait_over();
      drain();
    end

    // random phases: one long receiver hold-off, one stretch with no idling
    for (int ph = 0; ph < 3; ph++) begin
      random_config(ph == 2);
      no_idle = (ph == 1);
      if (ph == 0) begin
        hold_go = 1;
        repeat (12) push_byte(8'($urandom), 1'b1);
      end
      repeat (ph == 1 ? 2 : 1) random_frame();
      push_wait_over();
      drain();
    end
    no_idle = 0;

    $display("%0d frame verdicts (%0d decisive) and %0d final verdicts checked",
             n_frames, n_decisive, n_final);
    if (errors == 0) $display("TB_OK");
    else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
